[rtl/bpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the bitmap page allocator
// Page geometry, operation and status codes, config register indexes and the
// result word of the free-bit scan unit.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int unsigned ADDR_W        = 32;
	localparam int unsigned CNT_REG_W     = 11;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned BIT_W         = $clog2(WORD_W);
	localparam int unsigned MAX_PAGES_DEF = 1024;
	localparam int unsigned PAGE_BYTES    = 4096;
	localparam int unsigned PAGE_SHIFT    = $clog2(PAGE_BYTES);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOFREE     = 2'd1,
		ST_MISALIGNED = 2'd2,
		ST_RANGE      = 2'd3
	} status_t;

	typedef enum logic {
		CFG_BASE  = 1'b0,
		CFG_COUNT = 1'b1
	} cfg_idx_t;

	// Scan unit answer: lowest free, in-range bit of one map word
	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} scan_res_t;

endpackage

[rtl/bpa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_if: request and response channels of the bitmap page allocator
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface bpa_req_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [bpa_pkg::ADDR_W-1:0]  address;

	modport source (output valid, output opcode, output address, input ready);
	modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface bpa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bpa_pkg::ADDR_W-1:0]  page_address;
	logic [1:0]                  status;

	modport source (output valid, output page_address, output status, input ready);
	modport sink   (input valid, input page_address, input status, output ready);
endinterface

[rtl/bpa_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_map: used-bit map storage
// One word of used bits per 32 pages; one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bpa_map #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [bpa_pkg::WORD_W-1:0]  wr_data,
	input  logic [AW-1:0]               rd_addr,
	output logic [bpa_pkg::WORD_W-1:0]  rd_data
);
	import bpa_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

[rtl/bpa_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_scan: free-bit finder
// Masks off pages beyond the page count in the last word and returns the
// lowest clear bit of one map word.
// ----------------------------------------------------------------------------
module bpa_scan (
	input  logic [bpa_pkg::WORD_W-1:0]  word,
	input  logic                        last,
	input  logic [bpa_pkg::BIT_W-1:0]   lim,
	output bpa_pkg::scan_res_t          res
);
	import bpa_pkg::*;

	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] avail;

	// keep bits 0..lim in the last word, all bits elsewhere
	always_comb begin
		mask  = last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - lim)) : {WORD_W{1'b1}};
		avail = ~word & mask;
	end

	// priority encode, lowest free bit wins
	always_comb begin
		res.found = |avail;
		res.pos   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (avail[i]) begin
				res.pos = BIT_W'(i);
			end
		end
	end

endmodule

[rtl/bitmap_page_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core: first-fit page allocator over a used-bit map
// Allocate returns the lowest free page below the page count and marks it
// used; free checks the page address and clears its bit.
//
//   channel  dir  handshake     word contents
//   req      in   valid/ready   opcode, address
//   rsp      out  valid/ready   page_address, status
//   cfg      in   cfg_we        cfg_index, cfg_data (no read-back)
//
// Allocate scans one map word per cycle from the RAM port after its alloc
// step, reading the next word ahead, over 1 to 32 words at the default size;
// a find adds an address step before the response, no free page responds
// after the last page's word, and a zero page count skips the scan.
// Free steps through check, index compare and map read, map write, response
// and idle; a misaligned or below-base address responds after the check, an
// index beyond the page count after the index compare.
// After reset a clearing pass zeroes the map, one word a cycle; no request is
// taken meanwhile.
// One request is in flight at a time; a waiting response holds the block in
// its final state until the response register is free.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
	parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [bpa_pkg::ADDR_W-1:0]   cfg_data,
	bpa_req_if.sink                      req,
	bpa_rsp_if.source                    rsp
);
	import bpa_pkg::*;

	localparam int unsigned MAP_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned PW        = AW + BIT_W;
	localparam int unsigned CW        = $clog2(MAX_PAGES + 1);
	localparam int unsigned NW        = (CW > CNT_REG_W) ? CW : CNT_REG_W;
	localparam int unsigned FIW       = ADDR_W - PAGE_SHIFT;
	localparam int unsigned XW        = (FIW > CW) ? FIW : CW;

	typedef enum logic [8:0] {
		S_CLEAR    = 9'b000000001,
		S_IDLE     = 9'b000000010,
		S_ALLOC    = 9'b000000100,
		S_SCAN     = 9'b000001000,
		S_ADDR     = 9'b000010000,
		S_FREE_CHK = 9'b000100000,
		S_FREE_IDX = 9'b001000000,
		S_FREE_WR  = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [ADDR_W-1:0]     base_q;
	logic [CNT_REG_W-1:0]  count_q;
	logic                  rsp_valid_q;

	logic [ADDR_W-1:0]     addr_q;
	logic [CW-1:0]         n_q;
	logic                  nz_q;
	logic [AW-1:0]         lw_q;
	logic [BIT_W-1:0]      lim_q;
	logic [AW-1:0]         chk_q;
	logic [PW-1:0]         idx_q;
	logic [ADDR_W-1:0]     diff_q;
	logic [ADDR_W-1:0]     res_addr_q;
	status_t               res_st_q;
	logic [ADDR_W-1:0]     rsp_addr_q;
	status_t               rsp_st_q;

	logic [NW-1:0]         cnt_ext;
	logic [NW-1:0]         n_ext;
	logic [CW-1:0]         n_eff;
	logic [CW-1:0]         nm1;
	logic [FIW-1:0]        fidx;
	logic                  fidx_out;
	logic                  accept;
	logic                  last_word;
	logic                  rsp_load;
	logic [AW-1:0]         map_ra;
	logic                  map_we;
	logic [AW-1:0]         map_wa;
	logic [WORD_W-1:0]     map_wd;
	logic [WORD_W-1:0]     map_rd;
	scan_res_t             scan;

	// effective page count and the word that holds the last page
	always_comb begin
		cnt_ext = NW'(count_q);
		n_ext   = (cnt_ext > NW'(MAX_PAGES)) ? NW'(MAX_PAGES) : cnt_ext;
		n_eff   = CW'(n_ext);
		nm1     = n_eff - CW'(1);
	end

	assign accept    = req.valid && req.ready;
	assign last_word = (chk_q == lw_q);
	assign fidx      = FIW'(diff_q >> PAGE_SHIFT);
	assign fidx_out  = (XW'(fidx) >= XW'(n_q));
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	bpa_map #(
		.DEPTH (MAP_WORDS),
		.AW    (AW)
	) u_map (
		.clk     (clk),
		.wr_en   (map_we),
		.wr_addr (map_wa),
		.wr_data (map_wd),
		.rd_addr (map_ra),
		.rd_data (map_rd)
	);

	bpa_scan u_scan (
		.word (map_rd),
		.last (last_word),
		.lim  (lim_q),
		.res  (scan)
	);

	// map read address: prefetch the next word while scanning, the page's word on a free
	always_comb begin
		case (state_q)
			S_SCAN:     map_ra = last_word ? chk_q : chk_q + AW'(1);
			S_FREE_IDX: map_ra = AW'(fidx >> BIT_W);
			default:    map_ra = '0;
		endcase
	end

	// map write: clearing pass, allocate set, free clear
	always_comb begin
		map_we = 1'b0;
		map_wa = chk_q;
		map_wd = '0;
		case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
			end
			S_SCAN: begin
				map_we = scan.found;
				map_wa = chk_q;
				map_wd = map_rd | (WORD_W'(1) << scan.pos);
			end
			S_FREE_WR: begin
				map_we = 1'b1;
				map_wa = idx_q[PW-1:BIT_W];
				map_wd = map_rd & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BASE) begin
				base_q <= cfg_data;
			end else begin
				count_q <= cfg_data[CNT_REG_W-1:0];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= (req.opcode == OP_FREE) ? S_FREE_CHK : S_ALLOC;
					end
				end
				S_ALLOC: begin
					state_q <= nz_q ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					if (scan.found) begin
						state_q <= S_ADDR;
					end else if (last_word) begin
						state_q <= S_DONE;
					end
				end
				S_ADDR: begin
					state_q <= S_DONE;
				end
				S_FREE_CHK: begin
					if (addr_q[PAGE_SHIFT-1:0] != '0 || addr_q < base_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FREE_IDX;
					end
				end
				S_FREE_IDX: begin
					state_q <= fidx_out ? S_DONE : S_FREE_WR;
				end
				S_FREE_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				addr_q     <= req.address;
				n_q        <= n_eff;
				nz_q       <= (n_eff != '0);
				lw_q       <= AW'(nm1 >> BIT_W);
				lim_q      <= nm1[BIT_W-1:0];
				chk_q      <= '0;
				res_addr_q <= '0;
				res_st_q   <= ST_NOFREE;
			end
			S_SCAN: begin
				if (scan.found) begin
					idx_q <= {chk_q, scan.pos};
				end else if (!last_word) begin
					chk_q <= chk_q + AW'(1);
				end
			end
			S_ADDR: begin
				res_addr_q <= base_q + (ADDR_W'(idx_q) << PAGE_SHIFT);
				res_st_q   <= ST_OK;
			end
			S_FREE_CHK: begin
				diff_q <= addr_q - base_q;
				if (addr_q[PAGE_SHIFT-1:0] != '0) begin
					res_st_q <= ST_MISALIGNED;
				end else if (addr_q < base_q) begin
					res_st_q <= ST_RANGE;
				end
			end
			S_FREE_IDX: begin
				idx_q    <= PW'(fidx);
				res_st_q <= fidx_out ? ST_RANGE : ST_OK;
			end
			default: begin
				res_st_q <= res_st_q;
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_addr_q <= res_addr_q;
			rsp_st_q   <= res_st_q;
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.page_address = rsp_addr_q;
	assign rsp.status       = rsp_st_q;

`ifndef SYNTH
	// a response appears only out of the final state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside the final state");

	// the scan never runs past the word holding the last page
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (chk_q <= lw_q))
		else $error("scan beyond last map word");

	// an allocated page lies below the page count
	a_alloc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADDR) |-> (XW'(idx_q) < XW'(n_q)))
		else $error("allocated page beyond page count");

	// a free writes back its word with the page bit cleared
	a_free_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE_WR) |-> (map_we && !map_wd[idx_q[BIT_W-1:0]]))
		else $error("free did not clear the page bit");

	// an allocation marks the chosen bit used in the same write
	a_alloc_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && scan.found) |-> (map_we && map_wd[scan.pos]))
		else $error("allocation did not set the page bit");
`endif

endmodule
